@@ sv/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // heap geometry
    localparam int NUM_BLOCKS  = 256;
    localparam int BLOCK_BYTES = 64;
    localparam int ID_BITS     = 16;

    // field widths
    localparam int SIZE_W   = 16;
    localparam int INDEX_W  = 8;
    localparam int START_W  = 8;
    localparam int STATUS_W = 2;

    // internal widths
    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int NEED_W = SIZE_W + 1;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BADIDX  = 2'd3
    } t_status;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FREE,
        S_RESP
    } t_state;

endpackage

@@ sv/ffba_req_if.sv @@
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel of the block allocator: valid/ready with command payload.
// ----------------------------------------------------------------------------
interface ffba_req_if;

    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [ffba_pkg::SIZE_W-1:0]   size_bytes;
    logic [ffba_pkg::INDEX_W-1:0]  block_index;

    modport source (output valid, output command, output size_bytes,
                    output block_index, input ready);
    modport sink   (input valid, input command, input size_bytes,
                    input block_index, output ready);

endinterface

@@ sv/ffba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel of the block allocator: valid/ready with status payload.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::START_W-1:0]   start_index;

    modport source (output valid, output status, output start_index, input ready);
    modport sink   (input valid, input status, input start_index, output ready);

endinterface

@@ sv/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator of contiguous runs over a heap of equal blocks.
// ----------------------------------------------------------------------------
// The block owner tags live in a synchronous memory with one read and one
// write port, read one tag per cycle, and one request is handled at a time;
// each request gives exactly one response beat. An allocate scans from block
// 0, stopping early when a fitting run is found, then writes the owner id
// into each block of the run. A free walks and clears the run of blocks
// that carry the tag of the given block; zero size, oversize and bad index
// requests go straight to the response. Reset clears all tags at once through
// per-block valid bits, so the block takes requests right after reset. A
// finished response waits in an output register, and the next request is
// accepted while it waits.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);

    // tag memory and per-block valid bits
    logic [ffba_pkg::ID_BITS-1:0]    r_mem [ffba_pkg::NUM_BLOCKS];
    logic [ffba_pkg::NUM_BLOCKS-1:0] r_vld;
    logic [ffba_pkg::ID_BITS-1:0]    r_rdata;
    logic                            r_rd_vld;

    logic                            mem_re;
    logic                            mem_we;
    logic [ffba_pkg::IDX_W-1:0]      ra;
    logic [ffba_pkg::IDX_W-1:0]      wa;
    logic [ffba_pkg::ID_BITS-1:0]    wd;
    logic [ffba_pkg::ID_BITS-1:0]    rd_tag;

    // sequencer registers
    ffba_pkg::t_state                r_state, n_state;
    logic [ffba_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                            r_dv, n_dv;
    logic [ffba_pkg::CNT_W-1:0]      r_run, n_run;
    logic [ffba_pkg::CNT_W-1:0]      r_need, n_need;
    logic [ffba_pkg::IDX_W-1:0]      r_waddr, n_waddr;
    logic [ffba_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [ffba_pkg::ID_BITS-1:0]    r_tag, n_tag;
    logic                            r_first_rd, n_first_rd;
    logic [ffba_pkg::ID_BITS-1:0]    r_id, n_id;
    ffba_pkg::t_status               r_res_status, n_res_status;
    logic [ffba_pkg::START_W-1:0]    r_res_start, n_res_start;

    // output register
    logic                            r_ovalid;
    ffba_pkg::t_status               r_ostat;
    logic [ffba_pkg::START_W-1:0]    r_ostart;

    // decode and scan terms
    logic                            acc;
    logic                            out_free;
    logic                            req_zero;
    logic                            req_big;
    logic                            req_bad;
    logic [ffba_pkg::NEED_W-1:0]     need_full;
    logic                            idx_more;
    logic [ffba_pkg::CNT_W-1:0]      idx_m1;
    logic [ffba_pkg::CNT_W-1:0]      run_n;
    logic [ffba_pkg::CNT_W-1:0]      hit_first;
    logic                            scan_hit;
    logic                            scan_miss;
    logic                            free_match;
    logic                            free_done;
    logic [ffba_pkg::ID_BITS-1:0]    id_inc;

    // handshake
    assign i_req.ready = (r_state == ffba_pkg::S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;

    // request decode
    assign req_zero  = (i_req.size_bytes == '0);
    assign need_full = ffba_pkg::NEED_W'(i_req.size_bytes / ffba_pkg::BLOCK_BYTES)
                       + ffba_pkg::NEED_W'(1);
    assign req_big   = 32'(need_full) > 32'(ffba_pkg::NUM_BLOCKS);
    assign req_bad   = 32'(i_req.block_index) >= 32'(ffba_pkg::NUM_BLOCKS);

    // tag read data, unwritten blocks read as free
    assign rd_tag = r_rd_vld ? r_rdata : '0;

    // walk terms of scan and free
    assign idx_more  = (r_idx != ffba_pkg::CNT_W'(ffba_pkg::NUM_BLOCKS));
    assign idx_m1    = r_idx - ffba_pkg::CNT_W'(1);
    assign run_n     = (rd_tag == '0) ? r_run + ffba_pkg::CNT_W'(1) : '0;
    assign hit_first = r_idx - r_need;
    assign scan_hit  = r_dv && (run_n == r_need);
    assign scan_miss = r_dv && !scan_hit && !idx_more;
    assign free_match = r_first_rd ? (rd_tag != '0) : (rd_tag == r_tag);
    assign free_done  = r_dv && (!free_match || !idx_more);

    // owner id advance, skipping zero
    assign id_inc = r_id + ffba_pkg::ID_BITS'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (acc) begin
                    if (i_req.command == ffba_pkg::CMD_ALLOC) begin
                        n_state = (req_zero || req_big) ? ffba_pkg::S_RESP
                                                        : ffba_pkg::S_SCAN;
                    end else begin
                        n_state = req_bad ? ffba_pkg::S_RESP : ffba_pkg::S_FREE;
                    end
                end
            end
            ffba_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = ffba_pkg::S_FILL;
                end else if (scan_miss) begin
                    n_state = ffba_pkg::S_RESP;
                end
            end
            ffba_pkg::S_FILL: begin
                if (r_cnt == ffba_pkg::CNT_W'(1)) begin
                    n_state = ffba_pkg::S_RESP;
                end
            end
            ffba_pkg::S_FREE: begin
                if (free_done) begin
                    n_state = ffba_pkg::S_RESP;
                end
            end
            ffba_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        ra           = r_idx[ffba_pkg::IDX_W-1:0];
        wa           = r_waddr;
        wd           = r_id;
        n_idx        = r_idx;
        n_dv         = r_dv;
        n_run        = r_run;
        n_need       = r_need;
        n_waddr      = r_waddr;
        n_cnt        = r_cnt;
        n_tag        = r_tag;
        n_first_rd   = r_first_rd;
        n_id         = r_id;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (acc) begin
                    n_idx        = (i_req.command == ffba_pkg::CMD_ALLOC)
                                   ? '0 : ffba_pkg::CNT_W'(i_req.block_index);
                    n_dv         = 1'b0;
                    n_run        = '0;
                    n_need       = ffba_pkg::CNT_W'(need_full);
                    n_first_rd   = 1'b1;
                    n_res_start  = '0;
                    if (i_req.command == ffba_pkg::CMD_ALLOC) begin
                        n_res_status = req_zero ? ffba_pkg::ST_ZERO : ffba_pkg::ST_NOSPACE;
                    end else begin
                        n_res_status = ffba_pkg::ST_BADIDX;
                    end
                end
            end
            ffba_pkg::S_SCAN: begin
                // one tag read per cycle, data checked from the registered read port
                mem_re = idx_more;
                n_dv   = idx_more;
                if (idx_more) begin
                    n_idx = r_idx + ffba_pkg::CNT_W'(1);
                end
                if (r_dv) begin
                    n_run = run_n;
                end
                if (scan_hit) begin
                    n_waddr      = hit_first[ffba_pkg::IDX_W-1:0];
                    n_cnt        = r_need;
                    n_res_status = ffba_pkg::ST_OK;
                    n_res_start  = ffba_pkg::START_W'(hit_first);
                end else if (scan_miss) begin
                    n_res_status = ffba_pkg::ST_NOSPACE;
                    n_res_start  = '0;
                end
            end
            ffba_pkg::S_FILL: begin
                // tag the run one block per cycle
                mem_we  = 1'b1;
                n_waddr = r_waddr + ffba_pkg::IDX_W'(1);
                n_cnt   = r_cnt - ffba_pkg::CNT_W'(1);
                if (r_cnt == ffba_pkg::CNT_W'(1)) begin
                    n_id = (id_inc == '0) ? ffba_pkg::ID_BITS'(1) : id_inc;
                end
            end
            ffba_pkg::S_FREE: begin
                // read next tag, clear the one just checked
                mem_re = idx_more;
                n_dv   = idx_more;
                if (idx_more) begin
                    n_idx = r_idx + ffba_pkg::CNT_W'(1);
                end
                wa = idx_m1[ffba_pkg::IDX_W-1:0];
                wd = '0;
                if (r_dv) begin
                    n_first_rd = 1'b0;
                    if (r_first_rd) begin
                        n_tag = rd_tag;
                    end
                    mem_we = free_match;
                end
                if (free_done) begin
                    n_res_status = ffba_pkg::ST_OK;
                    n_res_start  = '0;
                end
            end
            ffba_pkg::S_RESP: begin
                n_dv = 1'b0;
            end
            default: n_dv = 1'b0;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
            r_dv    <= 1'b0;
            r_id    <= ffba_pkg::ID_BITS'(1);
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_id    <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_run        <= n_run;
        r_need       <= n_need;
        r_waddr      <= n_waddr;
        r_cnt        <= n_cnt;
        r_tag        <= n_tag;
        r_first_rd   <= n_first_rd;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
    end

    // tag memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wa] <= wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[ra];
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[wa] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_vld[ra];
            end
        end
    end

    // response output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ffba_pkg::S_RESP && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ffba_pkg::S_RESP && out_free) begin
            r_ostat  <= r_res_status;
            r_ostart <= r_res_start;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostat;
    assign o_rsp.start_index = r_ostart;

    // read and write never hit the same block in one cycle
    a_no_rw_same : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> wa != ra)
        else $error("tag read and write to same block");

    // owner id is never the free tag
    a_id_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id != '0)
        else $error("owner id is zero");

    // fill never runs with an empty count
    a_fill_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ffba_pkg::S_FILL |-> r_cnt != '0)
        else $error("fill with zero count");

    // error responses carry start index zero
    a_err_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostat != ffba_pkg::ST_OK |-> r_ostart == '0)
        else $error("nonzero start on error response");

    // owner id only moves at the end of a fill
    a_id_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id != $past(r_id) |-> $past(r_state) == ffba_pkg::S_FILL)
        else $error("owner id changed outside fill");

endmodule
